[src/rotor_substitution_cipher_defines.svh]
// ---------------------------------------------------------------------------
// Rotor substitution cipher: assertion macros
// Shared property templates for the checker of the cipher block.
// ---------------------------------------------------------------------------
`ifndef ROTOR_SUBSTITUTION_CIPHER_DEFINES_SVH
`define ROTOR_SUBSTITUTION_CIPHER_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define RSC_ASSERT_SAME(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define RSC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

[src/rsc_pkg.sv]
// ---------------------------------------------------------------------------
// Rotor substitution cipher package
// Wiring tables, item and cell control types shared by the cipher modules.
// ---------------------------------------------------------------------------
package rsc_pkg;

    localparam int ALPHA       = 26;
    localparam int NUM_WIRINGS = 9;
    localparam int CFG_DATA_W  = 5;
    localparam int CFG_IDX_W   = 3;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    typedef logic [4:0] t_letter;
    typedef logic [3:0] t_sel;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTOR_COUNT = 3'd0,
        CFG_SEL_A       = 3'd1,
        CFG_SEL_B       = 3'd2,
        CFG_SEL_C       = 3'd3,
        CFG_SEL_D       = 3'd4,
        CFG_ROTATION    = 3'd5
    } t_cfg_idx;

    // One character in flight through the rotor chain.
    typedef struct packed {
        logic       decrypt;
        logic       is_letter;
        logic       bad;
        logic [7:0] ch;
        t_letter    idx;
    } t_item;

    // Per-cell rotor control, derived from the configuration registers.
    typedef struct packed {
        logic    active;
        t_sel    sel_fwd;
        t_sel    sel_inv;
        t_letter rot;
    } t_cell_cfg;

    typedef logic [NUM_WIRINGS-1:0][ALPHA-1:0][4:0] t_tab;

    localparam logic [0:NUM_WIRINGS-1][8*ALPHA-1:0] WIRING_STR = {
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ",
        "EKMFLGDQVZNTOWYHXUSPAIBRCJ",
        "AJDKSIRUXBLHWTMCQGZNPYFVOE",
        "BDFHJLCPRTXVZNYEIWGAKMUSQO",
        "ESOVPZJAYQUIRHXLNFTGKDCMWB",
        "VZBRGITYUPSDNHLXAWMJQOFECK",
        "JPGVOUMFYQBENHZRDKASXLICTW",
        "NZJHGRCXMYSWBOUFAIVLPEKQDT",
        "FKQHTLXOCBJSPDZRAMEWNIUYGV"
    };

    // Forward table: position -> letter index.
    function automatic t_tab build_fwd();
        t_tab t;
        t = '0;
        for (int w = 0; w < NUM_WIRINGS; w++) begin
            for (int p = 0; p < ALPHA; p++) begin
                t[w][p] = 5'(WIRING_STR[w][8*(ALPHA-1-p) +: 8] - CHAR_A);
            end
        end
        return t;
    endfunction

    // Inverse table: letter index -> position.
    function automatic t_tab build_inv();
        t_tab f;
        t_tab t;
        f = build_fwd();
        t = '0;
        for (int w = 0; w < NUM_WIRINGS; w++) begin
            for (int p = 0; p < ALPHA; p++) begin
                t[w][f[w][p]] = 5'(p);
            end
        end
        return t;
    endfunction

    localparam t_tab FWD_TAB = build_fwd();
    localparam t_tab INV_TAB = build_inv();

endpackage

[src/rotor_substitution_cipher.sv]
// ---------------------------------------------------------------------------
// Rotor substitution cipher
// Streams characters through up to four rotated substitution rotors.
// ---------------------------------------------------------------------------
// The block takes one character request per cycle while o_in_stall is low and
// returns one result per request, in order. Each request goes through a row
// of MAX_ROTORS identical rotor cells, each one a register stage; cell k
// applies rotor k when encrypting and the inverse of rotor count-1-k when
// decrypting, and passes the character unchanged when k is beyond the active
// rotor count. The last cell's register is the output register, so a new
// request enters while a finished result waits, and o_in_stall rises only
// when every cell holds a request that the consumer has not yet taken.
// Spaces pass unchanged; anything that is not 'A'..'Z' or space passes
// unchanged with o_bad_char set. A rotor count above MAX_ROTORS acts as
// MAX_ROTORS, selectors 9..15 act as the identity wiring and a rotation of
// 26..31 is taken modulo 26. Write configuration only while no request is in
// flight.
// ---------------------------------------------------------------------------
module rotor_substitution_cipher #(
    parameter int MAX_ROTORS = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [rsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rsc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_req_type,
    input  logic [7:0]                       i_in_char,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [7:0]                       o_out_char,
    output logic                             o_bad_char
);

    // Configuration registers
    logic [2:0]       r_rotor_count;
    rsc_pkg::t_sel    r_sel [4];
    rsc_pkg::t_letter r_rotation;

    // Derived rotor control
    logic [2:0]         count_c;
    rsc_pkg::t_letter   rot_c;
    rsc_pkg::t_sel      sel_c [4];
    rsc_pkg::t_cell_cfg cell_cfg [MAX_ROTORS];

    // Cell chain
    logic           chain_valid [MAX_ROTORS+1];
    logic           chain_ready [MAX_ROTORS+1];
    rsc_pkg::t_item chain_item  [MAX_ROTORS+1];
    rsc_pkg::t_item last_item;

    // Take configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotor_count <= '0;
            r_rotation    <= '0;
            for (int i = 0; i < 4; i++) begin
                r_sel[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (rsc_pkg::t_cfg_idx'(i_cfg_index))
                rsc_pkg::CFG_ROTOR_COUNT: begin
                    r_rotor_count <= i_cfg_data[2:0];
                end
                rsc_pkg::CFG_SEL_A: begin
                    r_sel[0] <= i_cfg_data[3:0];
                end
                rsc_pkg::CFG_SEL_B: begin
                    r_sel[1] <= i_cfg_data[3:0];
                end
                rsc_pkg::CFG_SEL_C: begin
                    r_sel[2] <= i_cfg_data[3:0];
                end
                rsc_pkg::CFG_SEL_D: begin
                    r_sel[3] <= i_cfg_data[3:0];
                end
                rsc_pkg::CFG_ROTATION: begin
                    r_rotation <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Clip the rotor count, fold the rotation into 0..25 and map unknown
    // selectors to the identity wiring.
    always_comb begin
        count_c = (r_rotor_count > 3'(MAX_ROTORS)) ? 3'(MAX_ROTORS) : r_rotor_count;
        rot_c   = (r_rotation >= 5'(rsc_pkg::ALPHA)) ?
                  r_rotation - 5'(rsc_pkg::ALPHA) : r_rotation;
        for (int i = 0; i < 4; i++) begin
            sel_c[i] = (r_sel[i] >= 4'(rsc_pkg::NUM_WIRINGS)) ? '0 : r_sel[i];
        end
    end

    // Cell k runs rotor k forward, or rotor count-1-k in reverse.
    for (genvar k = 0; k < MAX_ROTORS; k++) begin : g_cfg
        logic [2:0] dec_slot;
        assign dec_slot            = count_c - 3'(k) - 3'd1;
        assign cell_cfg[k].active  = 3'(k) < count_c;
        assign cell_cfg[k].sel_fwd = sel_c[k];
        assign cell_cfg[k].sel_inv = sel_c[dec_slot[1:0]];
        assign cell_cfg[k].rot     = rot_c;
    end

    // Classify the incoming character.
    always_comb begin
        chain_item[0].decrypt   = i_req_type;
        chain_item[0].ch        = i_in_char;
        chain_item[0].is_letter = (i_in_char >= rsc_pkg::CHAR_A) &&
                                  (i_in_char <= rsc_pkg::CHAR_Z);
        chain_item[0].bad       = !chain_item[0].is_letter &&
                                  (i_in_char != rsc_pkg::CHAR_SPACE);
        chain_item[0].idx       = 5'(i_in_char - rsc_pkg::CHAR_A);
    end

    assign chain_valid[0] = i_in_valid;
    assign o_in_stall     = !chain_ready[0];

    for (genvar k = 0; k < MAX_ROTORS; k++) begin : g_cell
        rsc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cell_cfg[k]),
            .i_valid (chain_valid[k]),
            .i_item  (chain_item[k]),
            .o_ready (chain_ready[k]),
            .o_valid (chain_valid[k+1]),
            .o_item  (chain_item[k+1]),
            .i_ready (chain_ready[k+1])
        );
    end

    // The last cell holds the result until the consumer takes it.
    assign chain_ready[MAX_ROTORS] = !i_out_stall;
    assign last_item               = chain_item[MAX_ROTORS];
    assign o_out_valid             = chain_valid[MAX_ROTORS];
    assign o_out_char = last_item.is_letter ?
                        (8'(last_item.idx) + rsc_pkg::CHAR_A) : last_item.ch;
    assign o_bad_char = last_item.bad;

endmodule

[src/rsc_cell.sv]
// ---------------------------------------------------------------------------
// Rotor cell
// One pipeline stage that pushes a letter through one rotated rotor.
// ---------------------------------------------------------------------------
module rsc_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rsc_pkg::t_cell_cfg i_cfg,
    input  logic               i_valid,
    input  rsc_pkg::t_item     i_item,
    output logic               o_ready,
    output logic               o_valid,
    output rsc_pkg::t_item     o_item,
    input  logic               i_ready
);

    logic           r_valid;
    rsc_pkg::t_item r_item;
    rsc_pkg::t_item n_item;
    logic [5:0]     pos_fwd;
    logic [5:0]     sum_inv;
    rsc_pkg::t_letter fwd_idx;
    rsc_pkg::t_letter inv_idx;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        // Forward: position (x - rot) mod 26 of the wiring.
        if (i_item.idx >= i_cfg.rot) begin
            pos_fwd = {1'b0, i_item.idx} - {1'b0, i_cfg.rot};
        end else begin
            pos_fwd = {1'b0, i_item.idx} + 6'(rsc_pkg::ALPHA) - {1'b0, i_cfg.rot};
        end
        fwd_idx = rsc_pkg::FWD_TAB[i_cfg.sel_fwd][pos_fwd[4:0]];

        // Inverse: (position of letter + rot) mod 26.
        sum_inv = {1'b0, rsc_pkg::INV_TAB[i_cfg.sel_inv][i_item.idx]} + {1'b0, i_cfg.rot};
        if (sum_inv >= 6'(rsc_pkg::ALPHA)) begin
            sum_inv = sum_inv - 6'(rsc_pkg::ALPHA);
        end
        inv_idx = sum_inv[4:0];

        n_item = i_item;
        if (i_cfg.active && i_item.is_letter) begin
            n_item.idx = i_item.decrypt ? inv_idx : fwd_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

[src/rsc_checker.sv]
// ---------------------------------------------------------------------------
// Rotor substitution cipher checker
// Port-level properties of the cipher block, bound to its top level.
// ---------------------------------------------------------------------------
`include "rotor_substitution_cipher_defines.svh"

module rsc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_char,
    input logic       o_bad_char
);

    `RSC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        o_out_valid && i_out_stall,
        o_out_valid && $stable(o_out_char) && $stable(o_bad_char),
        "result changed while stalled")

    // A flagged character is never a letter or a space.
    `RSC_ASSERT_SAME(a_bad_class, i_clk, i_rst_n,
        o_out_valid && o_bad_char,
        (o_out_char < rsc_pkg::CHAR_A || o_out_char > rsc_pkg::CHAR_Z) &&
        o_out_char != rsc_pkg::CHAR_SPACE,
        "flagged result is a letter or space")

    // An unflagged result is always a letter or a space.
    `RSC_ASSERT_SAME(a_good_class, i_clk, i_rst_n,
        o_out_valid && !o_bad_char,
        (o_out_char >= rsc_pkg::CHAR_A && o_out_char <= rsc_pkg::CHAR_Z) ||
        o_out_char == rsc_pkg::CHAR_SPACE,
        "unflagged result outside alphabet")

    // Without back pressure from the consumer the chain never stalls requests.
    `RSC_ASSERT_SAME(a_no_false_stall, i_clk, i_rst_n,
        !i_out_stall, !o_in_stall,
        "request stalled with free output")

    // A stalled request always has a waiting result held by the consumer.
    `RSC_ASSERT_SAME(a_stall_cause, i_clk, i_rst_n,
        o_in_stall, o_out_valid && i_out_stall,
        "request stalled without a held result")

endmodule

bind rotor_substitution_cipher rsc_checker u_rsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_char  (o_out_char),
    .o_bad_char  (o_bad_char)
);
